[design/bcne_pkg.sv]
// Shared types and codes for the block comment name extractor.
// Used by bcne_decode, bcne_out_fifo and block_comment_name_extractor.
`timescale 1ns / 1ps
package bcne_pkg;

    localparam int StateW = 3;

    localparam logic [StateW-1:0] ST_OUTSIDE = 3'd0;
    localparam logic [StateW-1:0] ST_SLASH   = 3'd1;
    localparam logic [StateW-1:0] ST_INSIDE  = 3'd2;
    localparam logic [StateW-1:0] ST_STAR    = 3'd3;
    localparam logic [StateW-1:0] ST_NAME    = 3'd4;

    localparam logic [1:0] K_CONTENT = 2'd0;
    localparam logic [1:0] K_NAME    = 2'd1;
    localparam logic [1:0] K_COMMIT  = 2'd2;
    localparam logic [1:0] K_DISCARD = 2'd3;

    localparam logic [7:0] CH_NEWLINE   = 8'd10;
    localparam logic [7:0] CH_TAB       = 8'd9;
    localparam logic [7:0] CH_CR        = 8'd13;
    localparam logic [7:0] CH_SPACE     = 8'd32;
    localparam logic [7:0] CH_QUOTE     = 8'd34;
    localparam logic [7:0] CH_APOS      = 8'd39;
    localparam logic [7:0] CH_STAR      = 8'd42;
    localparam logic [7:0] CH_SLASH     = 8'd47;
    localparam logic [7:0] CH_EQUALS    = 8'd61;
    localparam logic [7:0] CH_BACKSLASH = 8'd92;
    localparam logic [7:0] CH_LOWER_N   = 8'd110;
    localparam logic [7:0] CH_MAX_ASCII = 8'd127;

    typedef struct packed {
        logic [1:0] kind;
        logic [6:0] data;
        logic       first_entry;
        logic       last;
    } result_t;

    // Results produced by one byte: count is 0, 1 or 2
    typedef struct packed {
        logic [1:0] count;
        result_t    r0;
        result_t    r1;
    } push_t;

    typedef struct packed {
        logic [StateW-1:0] state_next;
        logic              seen_next;
        push_t             push;
    } decode_t;

endpackage

[design/bcne_decode.sv]
// Per-byte parser step: next parse state, entry-seen flag and the beats to emit.
// Depends on bcne_pkg.
`timescale 1ns / 1ps
module bcne_decode (
    input  logic [bcne_pkg::StateW-1:0] state,
    input  logic                        entry_seen,
    input  logic [7:0]                  text_byte,
    output bcne_pkg::decode_t           dec
);
    import bcne_pkg::*;

    logic is_letter;
    logic is_blank;
    logic is_ascii;

    assign is_letter = (text_byte >= 8'd65 && text_byte <= 8'd90)
                    || (text_byte >= 8'd97 && text_byte <= 8'd122);
    assign is_blank  = (text_byte == CH_SPACE)
                    || (text_byte >= CH_TAB && text_byte <= CH_CR);
    assign is_ascii  = (text_byte >= CH_NEWLINE && text_byte <= CH_MAX_ASCII);

    always_comb
    begin
        dec.state_next = state;
        dec.seen_next  = entry_seen;
        dec.push.count = 2'd0;
        dec.push.r0    = '0;
        dec.push.r1    = '0;
        unique case (state)
            ST_SLASH:
            begin
                dec.state_next = (text_byte == CH_STAR) ? ST_INSIDE : ST_OUTSIDE;
            end
            ST_INSIDE:
            begin
                priority if (text_byte == CH_STAR)
                begin
                    dec.state_next = ST_STAR;
                end
                else if (text_byte == CH_NEWLINE)
                begin
                    dec.push.count   = 2'd2;
                    dec.push.r0.kind = K_CONTENT;
                    dec.push.r0.data = CH_BACKSLASH[6:0];
                    dec.push.r1.kind = K_CONTENT;
                    dec.push.r1.data = CH_LOWER_N[6:0];
                    dec.push.r1.last = 1'b1;
                end
                else if (text_byte == CH_QUOTE || text_byte == CH_BACKSLASH)
                begin
                    dec.push.count   = 2'd2;
                    dec.push.r0.kind = K_CONTENT;
                    dec.push.r0.data = CH_BACKSLASH[6:0];
                    dec.push.r1.kind = K_CONTENT;
                    dec.push.r1.data = text_byte[6:0];
                    dec.push.r1.last = 1'b1;
                end
                else if (is_ascii)
                begin
                    dec.push.count   = 2'd1;
                    dec.push.r0.kind = K_CONTENT;
                    dec.push.r0.data = text_byte[6:0];
                    dec.push.r0.last = 1'b1;
                end
                else
                begin
                    dec.push.count = 2'd0;
                end
            end
            ST_STAR:
            begin
                dec.state_next = (text_byte == CH_SLASH) ? ST_NAME : ST_INSIDE;
            end
            ST_NAME:
            begin
                priority if (is_blank)
                begin
                    dec.push.count = 2'd0;
                end
                else if (text_byte == CH_EQUALS)
                begin
                    dec.push.count          = 2'd1;
                    dec.push.r0.kind        = K_COMMIT;
                    dec.push.r0.first_entry = ~entry_seen;
                    dec.push.r0.last        = 1'b1;
                    dec.seen_next           = 1'b1;
                    dec.state_next          = ST_OUTSIDE;
                end
                else if (is_letter || text_byte == CH_APOS)
                begin
                    dec.push.count   = 2'd1;
                    dec.push.r0.kind = K_NAME;
                    dec.push.r0.data = text_byte[6:0];
                    dec.push.r0.last = 1'b1;
                end
                else
                begin
                    // drop the pending name; comment content stays with consumer
                    dec.push.count   = 2'd1;
                    dec.push.r0.kind = K_DISCARD;
                    dec.push.r0.last = 1'b1;
                    dec.state_next   = ST_OUTSIDE;
                end
            end
            default:
            begin
                // outside, and the unused codes behave the same
                dec.state_next = (text_byte == CH_SLASH) ? ST_SLASH : ST_OUTSIDE;
            end
        endcase
    end

endmodule

[design/bcne_out_fifo.sv]
// Two-entry result queue that drives the output stream.
// Depends on bcne_pkg.
`timescale 1ns / 1ps
module bcne_out_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  bcne_pkg::push_t   push,
    output logic [1:0]        free_slots,
    output logic              out_valid,
    input  logic              out_ready,
    output bcne_pkg::result_t out_beat
);
    import bcne_pkg::*;

    result_t    slot_reg [2];
    result_t    slot_next [2];
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic [1:0] count_ap;
    logic       pop;

    assign pop        = out_valid && out_ready;
    assign out_valid  = (count_reg != 2'd0);
    assign out_beat   = slot_reg[0];
    assign free_slots = 2'd2 - count_reg;

    always_comb
    begin
        count_ap     = count_reg - {1'b0, pop};
        slot_next[0] = pop ? slot_reg[1] : slot_reg[0];
        slot_next[1] = slot_reg[1];
        // append after the pop; a two-beat push only arrives into an empty queue
        if (push.count != 2'd0)
        begin
            if (count_ap[0])
            begin
                slot_next[1] = push.r0;
            end
            else
            begin
                slot_next[0] = push.r0;
            end
        end
        if (push.count == 2'd2)
        begin
            slot_next[1] = push.r1;
        end
        count_next = count_ap + push.count;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg[0] <= slot_next[0];
        slot_reg[1] <= slot_next[1];
    end

endmodule

[design/block_comment_name_extractor.sv]
// Block comment name extractor: byte stream in, content/name/commit beats out.
// Path: input byte register, decode, then the output queue registers.
// Throughput: one byte per cycle while each byte gives at most one beat and the
// output is ready; an escaped byte gives two beats and holds the input until
// the queue is empty.
// Reset: rst_n (async, active low) clears parse state, entry flag and queues.
// Depends on bcne_pkg, bcne_decode and bcne_out_fifo.
`timescale 1ns / 1ps
module block_comment_name_extractor (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] text_byte
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [6:0] data, [7] first_entry
    output logic [1:0] m_axis_tuser,   // [1:0] kind
    output logic       m_axis_tlast
);
    import bcne_pkg::*;

    logic              in_valid_reg;
    logic              in_valid_next;
    logic [7:0]        in_byte_reg;
    logic [StateW-1:0] parse_state_reg;
    logic              entry_seen_reg;
    decode_t           dec;
    push_t             push;
    logic [1:0]        free_slots;
    logic              fire;
    result_t           out_beat;

    bcne_decode u_decode (
        .state      (parse_state_reg),
        .entry_seen (entry_seen_reg),
        .text_byte  (in_byte_reg),
        .dec        (dec)
    );

    // advance the held byte only when the queue has room for all its beats
    assign fire          = in_valid_reg && (free_slots >= dec.push.count);
    assign s_axis_tready = !in_valid_reg || fire;
    assign in_valid_next = s_axis_tvalid || (in_valid_reg && !fire);

    always_comb
    begin
        push       = dec.push;
        push.count = fire ? dec.push.count : 2'd0;
    end

    bcne_out_fifo u_out_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .free_slots (free_slots),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_beat   (out_beat)
    );

    assign m_axis_tdata = {out_beat.first_entry, out_beat.data};
    assign m_axis_tuser = out_beat.kind;
    assign m_axis_tlast = out_beat.last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg    <= 1'b0;
            parse_state_reg <= ST_OUTSIDE;
            entry_seen_reg  <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            if (fire)
            begin
                parse_state_reg <= dec.state_next;
                entry_seen_reg  <= dec.seen_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_byte_reg <= s_axis_tdata;
        end
    end

endmodule
